FILE: rtl/planar_body_dynamics_step_defines.svh
// Assertion macros for the planar body dynamics block
`ifndef PLANAR_BODY_DYNAMICS_STEP_DEFINES_SVH
`define PLANAR_BODY_DYNAMICS_STEP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define PBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define PBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/pbd_pkg.sv
package pbd_pkg;

    localparam int TwoPiQ   = 411775;
    localparam int PiQ      = 205887;
    localparam int HalfPiQ  = 102944;
    // floor(2^50 / TwoPiQ): reciprocal for the heading reduction
    localparam logic [31:0] HeadingRecip = 32'd2734259988;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic signed [47:0] DispLimit  = 48'sd1099511627775;
    localparam logic [47:0] ParamReset = 48'd1099763288576;
    localparam int CordicSteps = 16;

    localparam logic [0:0] REQ_CMD  = 1'b0;
    localparam logic [0:0] REQ_TICK = 1'b1;

    localparam logic [1:0] REG_AXIS_X   = 2'd0;
    localparam logic [1:0] REG_AXIS_Y   = 2'd1;
    localparam logic [1:0] REG_AXIS_YAW = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_ADT,
        ST_HALF,
        ST_DISP,
        ST_TRIG_RED,
        ST_CORDIC,
        ST_ROT,
        ST_COMMIT,
        ST_OUT
    } pbd_state_t;

    typedef struct packed {
        logic       load_cmd;
        logic       start_tick;
        logic       acc_step;
        logic       div_start;
        logic       adt_step;
        logic       half_step;
        logic       disp_step;
        logic       trig_reduce;
        logic       cordic_step;
        logic       rot_step;
        logic       commit;
        logic       clr_axis;
        logic       next_axis;
    } pbd_cmd_t;

    typedef struct packed {
        logic       div_done;
        logic       axis_last;
        logic       cordic_last;
        logic       rot_last;
    } pbd_status_t;

    typedef struct packed {
        logic              req_type;
        logic signed [15:0] thrust_x;
        logic signed [15:0] thrust_y;
        logic signed [15:0] thrust_yaw;
        logic [15:0]       tick_duration;
    } pbd_req_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_yaw;
        logic               saturated;
    } pbd_rsp_t;

    function automatic logic [31:0] atan_entry(input logic [3:0] i);
        logic [31:0] v;
        case (i)
            4'd0:    v = 32'd51472;
            4'd1:    v = 32'd30386;
            4'd2:    v = 32'd16055;
            4'd3:    v = 32'd8150;
            4'd4:    v = 32'd4091;
            4'd5:    v = 32'd2047;
            4'd6:    v = 32'd1024;
            4'd7:    v = 32'd512;
            4'd8:    v = 32'd256;
            4'd9:    v = 32'd128;
            4'd10:   v = 32'd64;
            4'd11:   v = 32'd32;
            4'd12:   v = 32'd16;
            4'd13:   v = 32'd8;
            4'd14:   v = 32'd4;
            default: v = 32'd2;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/pbd_stream_if.sv
interface pbd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/pbd_divider.sv
// Restoring divider: unsigned 48-bit magnitude by 16-bit, one bit a cycle
module pbd_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [48:0]  num,
    input  logic [15:0]         den,
    output logic                done,
    output logic signed [48:0]  quo
);
    logic [47:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    // one quotient bit per cycle
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[15:0], q_reg[47]};
        if (start)
        begin
            q_next    = num[48] ? 48'(-num) : num[47:0];
            r_next    = '0;
            d_next    = den;
            neg_next  = num[48];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[46:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                r_next    = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = trial;
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
endmodule

FILE: rtl/pbd_ctrl.sv
// Sequencer for command and tick items
module pbd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 in_is_tick,
    input  logic                 out_busy,
    input  pbd_pkg::pbd_status_t status,
    output logic                 in_ready,
    output logic                 out_load,
    output pbd_pkg::pbd_cmd_t    cmd
);
    pbd_pkg::pbd_state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pbd_pkg::ST_IDLE:
                if (in_fire)
                    state_next = in_is_tick ? pbd_pkg::ST_ACC : pbd_pkg::ST_OUT;
            pbd_pkg::ST_ACC:      state_next = pbd_pkg::ST_DIV;
            pbd_pkg::ST_DIV:
                if (status.div_done)
                    state_next = pbd_pkg::ST_ADT;
            pbd_pkg::ST_ADT:      state_next = pbd_pkg::ST_HALF;
            pbd_pkg::ST_HALF:     state_next = pbd_pkg::ST_DISP;
            pbd_pkg::ST_DISP:
                state_next = status.axis_last ? pbd_pkg::ST_TRIG_RED : pbd_pkg::ST_ACC;
            pbd_pkg::ST_TRIG_RED: state_next = pbd_pkg::ST_CORDIC;
            pbd_pkg::ST_CORDIC:
                if (status.cordic_last)
                    state_next = pbd_pkg::ST_ROT;
            pbd_pkg::ST_ROT:
                if (status.rot_last)
                    state_next = pbd_pkg::ST_COMMIT;
            pbd_pkg::ST_COMMIT:   state_next = pbd_pkg::ST_OUT;
            pbd_pkg::ST_OUT:
                if (!out_busy)
                    state_next = pbd_pkg::ST_IDLE;
            default:              state_next = pbd_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            pbd_pkg::ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.load_cmd   = in_fire && !in_is_tick;
                cmd.start_tick = in_fire && in_is_tick;
                cmd.clr_axis   = in_fire;
            end
            pbd_pkg::ST_ACC:      cmd.acc_step = 1'b1;
            pbd_pkg::ST_DIV:      cmd.div_start = 1'b0;
            pbd_pkg::ST_ADT:      cmd.adt_step = 1'b1;
            pbd_pkg::ST_HALF:     cmd.half_step = 1'b1;
            pbd_pkg::ST_DISP:
            begin
                cmd.disp_step = 1'b1;
                cmd.next_axis = 1'b1;
            end
            pbd_pkg::ST_TRIG_RED: cmd.trig_reduce = 1'b1;
            pbd_pkg::ST_CORDIC:   cmd.cordic_step = 1'b1;
            pbd_pkg::ST_ROT:      cmd.rot_step = 1'b1;
            pbd_pkg::ST_COMMIT:   cmd.commit = 1'b1;
            pbd_pkg::ST_OUT:      out_load = !out_busy;
            default:              cmd = '0;
        endcase
        cmd.div_start = (state_reg == pbd_pkg::ST_ACC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pbd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

FILE: rtl/pbd_datapath.sv
// State registers and shared arithmetic for one item
module pbd_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pbd_pkg::pbd_cmd_t    cmd,
    input  pbd_pkg::pbd_req_t    req,
    input  logic [47:0]          params_x,
    input  logic [47:0]          params_y,
    input  logic [47:0]          params_yaw,
    output pbd_pkg::pbd_status_t status,
    output pbd_pkg::pbd_rsp_t    rsp
);
    // architectural state
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic [47:0]        thr_reg;
    logic               sat_reg;
    // per-tick working values
    logic [15:0]        dt_reg;
    logic [1:0]         axis_reg;
    logic signed [48:0] acc_reg;
    logic signed [48:0] adt_reg [3];
    logic signed [48:0] half_reg;
    logic signed [47:0] disp_reg [3];
    logic               acc_zero_reg;
    logic [12:0]        hq_reg;
    // trig
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [31:0] r_reg;
    logic               flip_reg;
    logic [3:0]         it_reg;
    logic signed [18:0] c_reg, s_reg;
    logic [1:0]         rot_reg;
    logic signed [57:0] wx_reg, wy_reg;

    logic [47:0]        prm;
    logic signed [15:0] thr;
    logic signed [31:0] vel;
    logic signed [48:0] gain_w, damp_w, thr_w, vel_w;
    logic signed [48:0] num;
    logic signed [48:0] quo;
    logic               div_done;

    // axis operands and acceleration numerator
    always_comb
    begin
        case (axis_reg)
            2'd0:    prm = params_x;
            2'd1:    prm = params_y;
            default: prm = params_yaw;
        endcase
        thr    = $signed(thr_reg[16*axis_reg +: 16]);
        vel    = vel_reg[axis_reg];
        gain_w = 49'(prm[15:0]);
        damp_w = 49'(prm[31:16]);
        thr_w  = 49'(thr);
        vel_w  = 49'(vel);
        num    = gain_w * thr_w * 49'sd256 - damp_w * vel_w;
    end

    pbd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num),
        .den   (prm[47:32]),
        .done  (div_done),
        .quo   (quo)
    );

    // truncating toward zero multiply by dt
    function automatic logic signed [48:0] mul_dt(input logic signed [48:0] a,
                                                  input logic [15:0] b,
                                                  input logic odd);
        logic [47:0] m;
        logic [63:0] p;
        logic [48:0] pm;
        m  = a[48] ? 48'(-a) : a[47:0];
        p  = m * b;
        p  = odd ? (p >> 17) : (p >> 16);
        pm = {1'b0, p[47:0]};
        return a[48] ? -pm : pm;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [49:0] v,
                                                  output logic s);
        s = 1'b0;
        if (v > 50'sd2147483647)
        begin
            s = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -50'sd2147483648)
        begin
            s = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    logic signed [48:0] dsum;
    logic signed [31:0] red;
    logic signed [31:0] hm;
    logic [31:0]        habs;
    logic [63:0]        hprod;
    logic [31:0]        hqd, hrem;
    logic signed [33:0] dxs, dys;
    logic signed [66:0] prod;
    logic signed [47:0] pa, pb;
    logic signed [18:0] pc;
    logic signed [31:0] np [3];
    logic signed [31:0] nv [3];
    logic [5:0]         s6;

    always_comb
    begin
        dsum = mul_dt(49'(vel), dt_reg, 1'b0) + half_reg;
        // heading remainder by 2pi through a reciprocal quotient estimate
        habs  = pos_reg[2][31] ? 32'(-pos_reg[2]) : pos_reg[2];
        hprod = habs * pbd_pkg::HeadingRecip;
        hqd   = 32'(hq_reg) * 32'(pbd_pkg::TwoPiQ);
        hrem  = habs - hqd;
        if (hrem >= 32'(pbd_pkg::TwoPiQ))
            hrem = hrem - 32'(pbd_pkg::TwoPiQ);
        hm  = pos_reg[2][31] ? -$signed(hrem) : $signed(hrem);
        // heading wrapped into [-pi, pi); the fold into [-pi/2, pi/2] with sign flip is done at trig_reduce
        red = hm;
        if (red < 0)
            red = red + pbd_pkg::TwoPiQ;
        if (red >= pbd_pkg::PiQ)
            red = red - pbd_pkg::TwoPiQ;
        dxs = cy_reg >>> it_reg;
        dys = cx_reg >>> it_reg;
        // rotation products, one per cycle
        case (rot_reg)
            2'd0:    begin pa = disp_reg[0]; pc = c_reg; end
            2'd1:    begin pa = disp_reg[1]; pc = -s_reg; end
            2'd2:    begin pa = disp_reg[0]; pc = s_reg; end
            default: begin pa = disp_reg[1]; pc = c_reg; end
        endcase
        pb   = pa;
        prod = pb * pc;
        for (int i = 0; i < 3; i++)
        begin
            np[i] = '0;
            nv[i] = '0;
        end
        np[0] = clip32(50'(pos_reg[0]) + 50'(wx_reg >>> 15), s6[0]);
        np[1] = clip32(50'(pos_reg[1]) + 50'(wy_reg >>> 15), s6[1]);
        np[2] = clip32(50'(pos_reg[2]) + 50'(disp_reg[2]), s6[2]);
        nv[0] = clip32(50'(vel_reg[0]) + 50'(adt_reg[0]), s6[3]);
        nv[1] = clip32(50'(vel_reg[1]) + 50'(adt_reg[1]), s6[4]);
        nv[2] = clip32(50'(vel_reg[2]) + 50'(adt_reg[2]), s6[5]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
            thr_reg  <= '0;
            sat_reg  <= 1'b0;
            axis_reg <= '0;
            it_reg   <= '0;
            rot_reg  <= '0;
        end
        else
        begin
            if (cmd.load_cmd)
            begin
                thr_reg <= {req.thrust_yaw, req.thrust_y, req.thrust_x};
                sat_reg <= 1'b0;
            end
            if (cmd.start_tick)
            begin
                dt_reg  <= req.tick_duration;
                sat_reg <= 1'b0;
                hq_reg  <= 13'(hprod >> 50);
            end
            if (cmd.clr_axis)
                axis_reg <= '0;
            if (cmd.acc_step)
                acc_zero_reg <= (prm[47:32] == 16'd0);
            if (div_done)
                acc_reg <= acc_zero_reg ? '0 : quo;
            if (cmd.adt_step)
                adt_reg[axis_reg] <= mul_dt(acc_reg, dt_reg, 1'b0);
            if (cmd.half_step)
                half_reg <= mul_dt(adt_reg[axis_reg], dt_reg, 1'b1);
            if (cmd.disp_step)
            begin
                if (dsum > 49'(pbd_pkg::DispLimit))
                begin
                    disp_reg[axis_reg] <= pbd_pkg::DispLimit;
                    sat_reg <= 1'b1;
                end
                else if (dsum < -49'(pbd_pkg::DispLimit))
                begin
                    disp_reg[axis_reg] <= -pbd_pkg::DispLimit;
                    sat_reg <= 1'b1;
                end
                else
                    disp_reg[axis_reg] <= dsum[47:0];
            end
            if (cmd.next_axis)
                axis_reg <= axis_reg + 2'd1;
            if (cmd.trig_reduce)
            begin
                flip_reg <= 1'b0;
                r_reg    <= red;
                if (red > pbd_pkg::HalfPiQ)
                begin
                    r_reg    <= red - pbd_pkg::PiQ;
                    flip_reg <= 1'b1;
                end
                else if (red < -pbd_pkg::HalfPiQ)
                begin
                    r_reg    <= red + pbd_pkg::PiQ;
                    flip_reg <= 1'b1;
                end
                cx_reg <= pbd_pkg::CordicGain;
                cy_reg <= '0;
                it_reg <= '0;
                rot_reg <= '0;
            end
            if (cmd.cordic_step)
            begin
                if (r_reg >= 0)
                begin
                    cx_reg <= cx_reg - dxs;
                    cy_reg <= cy_reg + dys;
                    r_reg  <= r_reg - $signed(pbd_pkg::atan_entry(it_reg));
                end
                else
                begin
                    cx_reg <= cx_reg + dxs;
                    cy_reg <= cy_reg - dys;
                    r_reg  <= r_reg + $signed(pbd_pkg::atan_entry(it_reg));
                end
                it_reg <= it_reg + 4'd1;
                if (it_reg == 4'd15)
                begin
                    c_reg <= flip_reg ? -19'((cx_reg + dxs) >>> 15) : 19'((cx_reg + dxs) >>> 15);
                    s_reg <= flip_reg ? -19'((cy_reg - dys) >>> 15) : 19'((cy_reg - dys) >>> 15);
                    if (r_reg >= 0)
                    begin
                        c_reg <= flip_reg ? -19'((cx_reg - dxs) >>> 15)
                                          : 19'((cx_reg - dxs) >>> 15);
                        s_reg <= flip_reg ? -19'((cy_reg + dys) >>> 15)
                                          : 19'((cy_reg + dys) >>> 15);
                    end
                end
            end
            if (cmd.rot_step)
            begin
                case (rot_reg)
                    2'd0:    wx_reg <= 58'(prod);
                    2'd1:    wx_reg <= wx_reg + 58'(prod);
                    2'd2:    wy_reg <= 58'(prod);
                    default: wy_reg <= wy_reg + 58'(prod);
                endcase
                rot_reg <= rot_reg + 2'd1;
            end
            if (cmd.commit)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pos_reg[i] <= np[i];
                    vel_reg[i] <= nv[i];
                end
                if (|s6)
                    sat_reg <= 1'b1;
            end
        end
    end

    assign status.div_done    = div_done;
    assign status.axis_last   = (axis_reg == 2'd2);
    assign status.cordic_last = (it_reg == 4'd15);
    assign status.rot_last    = (rot_reg == 2'd3);

    assign rsp.pos_x     = pos_reg[0];
    assign rsp.pos_y     = pos_reg[1];
    assign rsp.heading   = pos_reg[2];
    assign rsp.vel_x     = vel_reg[0];
    assign rsp.vel_y     = vel_reg[1];
    assign rsp.vel_yaw   = vel_reg[2];
    assign rsp.saturated = sat_reg;
endmodule

FILE: rtl/planar_body_dynamics_step.sv
// Planar body dynamics step.
// Command item: loads the thrust; its result is registered from the output state.
// Tick item: per axis an acceleration step, the 48-step division, the dt product, the
// half-dt product and the displacement, then reduce, CORDIC, rotate, commit, output.
// One item at a time; output stalls hold it in its output state. rst_n (async, low)
// clears pose, velocity and thrust; axis params reset to mass 1.0, damping 15.0, gain 10.0.
`include "planar_body_dynamics_step_defines.svh"
module planar_body_dynamics_step (
    input  logic        clk,
    input  logic        rst_n,
    pbd_stream_if.sink   req,
    pbd_stream_if.source rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [47:0] prm_reg [3];
    logic        in_ready, out_load, in_fire;
    logic        ov_reg;
    pbd_pkg::pbd_rsp_t    od_reg;
    pbd_pkg::pbd_cmd_t    cmd;
    pbd_pkg::pbd_status_t status;
    pbd_pkg::pbd_rsp_t    dp_rsp;
    logic [1:0]  ridx;

    assign pready  = 1'b1;
    assign ridx    = paddr[4:3];
    assign in_fire = req.valid && in_ready;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                prm_reg[i] <= pbd_pkg::ParamReset;
        end
        else if (psel && penable && pwrite && paddr[4:3] != 2'd3)
            prm_reg[ridx] <= pwdata[47:0];
    end

    always_comb
    begin
        case (ridx)
            pbd_pkg::REG_AXIS_X:   prdata = {16'd0, prm_reg[0]};
            pbd_pkg::REG_AXIS_Y:   prdata = {16'd0, prm_reg[1]};
            pbd_pkg::REG_AXIS_YAW: prdata = {16'd0, prm_reg[2]};
            default:               prdata = '0;
        endcase
    end

    pbd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_is_tick (req.data.req_type == pbd_pkg::REQ_TICK),
        .out_busy   (ov_reg && !rsp.ready),
        .status     (status),
        .in_ready   (in_ready),
        .out_load   (out_load),
        .cmd        (cmd)
    );

    pbd_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req        (req.data),
        .params_x   (prm_reg[0]),
        .params_y   (prm_reg[1]),
        .params_yaw (prm_reg[2]),
        .status     (status),
        .rsp        (dp_rsp)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (out_load)
            ov_reg <= 1'b1;
        else if (rsp.ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            od_reg <= dp_rsp;
    end

    assign req.ready = in_ready;
    assign rsp.valid = ov_reg;
    assign rsp.data  = od_reg;

    `PBD_ASSERT_IMPL(a_load_free, clk, rst_n, out_load, !(ov_reg && !rsp.ready))
    `PBD_ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.load_cmd, cmd.start_tick}))
    `PBD_ASSERT_NEXT(a_hold, clk, rst_n, ov_reg && !rsp.ready, ov_reg && $stable(od_reg))
endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import pbd_pkg::*;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  DRAIN_CYCLES = 400;
    localparam longint QUIET_FROM = 30000;
    localparam longint QUIET_TO = 90000;
    localparam longint ATAN_Q [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    pbd_stream_if #(.payload_t(pbd_req_t)) req_if ();
    pbd_stream_if #(.payload_t(pbd_rsp_t)) rsp_if ();

    planar_body_dynamics_step dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if.sink),
        .rsp     (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // body state and axis parameters as the block should hold them
    int          body_pos_x, body_pos_y, body_heading;
    int          body_vel_x, body_vel_y, body_vel_yaw;
    shortint     thrust_hold [3];
    logic [47:0] axis_cfg [3];
    bit          clip_seen;

    pbd_req_t    pending_items [$];
    pbd_rsp_t    expected_states [$];
    longint      cycle_count;
    int          mismatch_count;
    bit          req_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", field, got, want);
        mismatch_count++;
    endtask

    function automatic int sat32(input longint v);
        if (v > 64'sd2147483647)
        begin
            clip_seen = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            clip_seen = 1'b1;
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    function automatic longint sat_disp(input longint v);
        longint lim;
        lim = longint'(DispLimit);
        if (v > lim)
        begin
            clip_seen = 1'b1;
            return lim;
        end
        if (v < -lim)
        begin
            clip_seen = 1'b1;
            return -lim;
        end
        return v;
    endfunction

    // magnitude product and shift, truncated toward zero
    function automatic longint scale_trunc(input longint a, input longint b, input int sh);
        longint unsigned m;
        m = (a < 0) ? longint'(-a) : a;
        m = (m * longint'(b)) >> sh;
        return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint axis_accel(input logic [47:0] p, input shortint thr,
                                          input int vel);
        longint mass, damp, gain, num;
        mass = longint'(p[47:32]);
        damp = longint'(p[31:16]);
        gain = longint'(p[15:0]);
        if (mass == 0)
            return 0;
        num = gain * longint'(thr) * 256 - damp * longint'(vel);
        return num / mass;
    endfunction

    // heading reduction, quadrant fold and CORDIC rotation
    task automatic heading_trig(input int h, output longint c, output longint s);
        longint r, x, y, dxs, dys;
        bit     flip;
        r = longint'(h) % TwoPiQ;
        x = longint'(CordicGain);
        y = 0;
        flip = 1'b0;
        if (r < 0)
            r += TwoPiQ;
        if (r >= PiQ)
            r -= TwoPiQ;
        if (r > HalfPiQ)
        begin
            r -= PiQ;
            flip = 1'b1;
        end
        else if (r < -HalfPiQ)
        begin
            r += PiQ;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++)
        begin
            dxs = y >>> i;
            dys = x >>> i;
            if (r >= 0)
            begin
                x -= dxs;
                y += dys;
                r -= ATAN_Q[i];
            end
            else
            begin
                x += dxs;
                y -= dys;
                r += ATAN_Q[i];
            end
        end
        c = x >>> 15;
        s = y >>> 15;
        if (flip)
        begin
            c = -c;
            s = -s;
        end
    endtask

    task automatic advance_body(input pbd_req_t it, output pbd_rsp_t res);
        longint dt, ax, ay, aw, adx, ady, adw, dx, dy, dw, c, s, wx, wy;
        clip_seen = 1'b0;
        if (it.req_type == REQ_CMD)
        begin
            thrust_hold[0] = it.thrust_x;
            thrust_hold[1] = it.thrust_y;
            thrust_hold[2] = it.thrust_yaw;
        end
        else
        begin
            dt = longint'(it.tick_duration);
            ax = axis_accel(axis_cfg[0], thrust_hold[0], body_vel_x);
            ay = axis_accel(axis_cfg[1], thrust_hold[1], body_vel_y);
            aw = axis_accel(axis_cfg[2], thrust_hold[2], body_vel_yaw);
            adx = scale_trunc(ax, dt, 16);
            ady = scale_trunc(ay, dt, 16);
            adw = scale_trunc(aw, dt, 16);
            dx = sat_disp(scale_trunc(body_vel_x, dt, 16) + scale_trunc(adx, dt, 17));
            dy = sat_disp(scale_trunc(body_vel_y, dt, 16) + scale_trunc(ady, dt, 17));
            dw = sat_disp(scale_trunc(body_vel_yaw, dt, 16) + scale_trunc(adw, dt, 17));
            heading_trig(body_heading, c, s);
            wx = (c * dx - s * dy) >>> 15;
            wy = (s * dx + c * dy) >>> 15;
            body_pos_x = sat32(longint'(body_pos_x) + wx);
            body_pos_y = sat32(longint'(body_pos_y) + wy);
            body_heading = sat32(longint'(body_heading) + dw);
            body_vel_x = sat32(longint'(body_vel_x) + adx);
            body_vel_y = sat32(longint'(body_vel_y) + ady);
            body_vel_yaw = sat32(longint'(body_vel_yaw) + adw);
        end
        res.pos_x = body_pos_x;
        res.pos_y = body_pos_y;
        res.heading = body_heading;
        res.vel_x = body_vel_x;
        res.vel_y = body_vel_y;
        res.vel_yaw = body_vel_yaw;
        res.saturated = clip_seen;
    endtask

    function automatic bit take_break();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 7;
    endfunction

    // request driver and result back-pressure
    always @(negedge clk)
    begin
        pbd_req_t nxt;
        bit       drive;
        if (rst_n)
        begin
            if (!req_if.valid || req_taken)
            begin
                drive = pending_items.size() != 0 && !take_break();
                if (drive)
                    nxt = pending_items.pop_front();
                else
                    nxt = req_if.data;
                req_if.valid <= drive;
                req_if.data <= nxt;
            end
            rsp_if.ready <= !take_break();
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        pbd_rsp_t want, got;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.data;
                if (expected_states.size() == 0)
                    report("unexpected result", 0, 0);
                else
                begin
                    want = expected_states.pop_front();
                    if (got.pos_x !== want.pos_x)
                        report("pos_x", got.pos_x, want.pos_x);
                    if (got.pos_y !== want.pos_y)
                        report("pos_y", got.pos_y, want.pos_y);
                    if (got.heading !== want.heading)
                        report("heading", got.heading, want.heading);
                    if (got.vel_x !== want.vel_x)
                        report("vel_x", got.vel_x, want.vel_x);
                    if (got.vel_y !== want.vel_y)
                        report("vel_y", got.vel_y, want.vel_y);
                    if (got.vel_yaw !== want.vel_yaw)
                        report("vel_yaw", got.vel_yaw, want.vel_yaw);
                    if (got.saturated !== want.saturated)
                        report("saturated", got.saturated, want.saturated);
                end
            end
            req_taken = req_if.valid && req_if.ready;
            if (req_taken)
            begin
                advance_body(req_if.data, want);
                expected_states.push_back(want);
            end
        end
    end

    task automatic write_axis(input logic [1:0] idx, input logic [47:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = 5'(idx) << 3;
        pwdata = {16'h0, value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        axis_cfg[idx] = value;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_axes(input logic [47:0] px, input logic [47:0] py,
                            input logic [47:0] pw);
        write_axis(REG_AXIS_X, px);
        write_axis(REG_AXIS_Y, py);
        write_axis(REG_AXIS_YAW, pw);
    endtask

    task automatic queue_item(input logic kind, input int tx, input int ty, input int tw,
                              input int dt);
        pbd_req_t it;
        it.req_type = kind;
        it.thrust_x = 16'(tx);
        it.thrust_y = 16'(ty);
        it.thrust_yaw = 16'(tw);
        it.tick_duration = 16'(dt);
        pending_items.push_back(it);
    endtask

    task automatic queue_random(input int count);
        int dt, mode;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 3)
            begin
                if ($urandom_range(0, 1))
                    queue_item(REQ_CMD, $urandom, $urandom, $urandom, $urandom);
                else
                    queue_item(REQ_CMD, $urandom_range(0, 1023) - 512,
                               $urandom_range(0, 1023) - 512,
                               $urandom_range(0, 1023) - 512, $urandom);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       dt = 0;
                    1:       dt = 65535;
                    2, 3, 4: dt = $urandom_range(0, 65535);
                    default: dt = $urandom_range(1, 3000);
                endcase
                queue_item(REQ_TICK, $urandom, $urandom, $urandom, dt);
            end
        end
    endtask

    task automatic drain_all();
        while (pending_items.size() != 0 || req_if.valid || expected_states.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [47:0] rand_params();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    // stimulus phases
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        req_taken = 1'b0;
        body_pos_x = 0; body_pos_y = 0; body_heading = 0;
        body_vel_x = 0; body_vel_y = 0; body_vel_yaw = 0;
        for (int i = 0; i < 3; i++)
        begin
            thrust_hold[i] = 0;
            axis_cfg[i] = ParamReset;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset parameters, field extremes, zero and full duration
        queue_item(REQ_TICK, 0, 0, 0, 65535);
        queue_item(REQ_CMD, 32767, 32767, 32767, 65535);
        queue_item(REQ_TICK, -1, -1, -1, 0);
        queue_item(REQ_TICK, 0, 0, 0, 65535);
        queue_item(REQ_TICK, 0, 0, 0, 1);
        queue_item(REQ_TICK, 0, 0, 0, 32768);
        queue_item(REQ_CMD, -32768, -32768, -32768, 0);
        queue_item(REQ_TICK, 0, 0, 0, 65535);
        queue_item(REQ_TICK, 0, 0, 0, 65535);
        queue_item(REQ_CMD, 0, 0, 0, 0);
        queue_item(REQ_TICK, 0, 0, 0, 65535);
        drain_all();

        // mass zero on every axis, extremes of damping and gain
        set_axes(48'h0000_FFFF_FFFF, 48'h0000_0000_FFFF, 48'h0000_FFFF_0000);
        queue_item(REQ_CMD, 32767, -32768, 32767, 0);
        queue_item(REQ_TICK, 0, 0, 0, 65535);
        queue_item(REQ_TICK, 0, 0, 0, 0);
        drain_all();

        // tiny mass, full gain and damping: velocity and displacement clipping
        set_axes(48'h0001_FFFF_FFFF, 48'h0001_FFFF_FFFF, 48'h0001_FFFF_FFFF);
        queue_item(REQ_CMD, 32767, -32768, 32767, 0);
        queue_item(REQ_TICK, 0, 0, 0, 65535);
        queue_item(REQ_TICK, 0, 0, 0, 65535);
        queue_item(REQ_TICK, 0, 0, 0, 65535);
        queue_item(REQ_CMD, -32768, 32767, -32768, 0);
        queue_item(REQ_TICK, 0, 0, 0, 65535);
        queue_random(230);
        drain_all();

        // reset-like parameters with random traffic
        set_axes(ParamReset, ParamReset, ParamReset);
        queue_random(280);
        drain_all();

        // all ones
        set_axes(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_random(230);
        drain_all();

        // all zero
        set_axes(48'h0, 48'h0, 48'h0);
        queue_random(100);
        drain_all();

        // random parameter sets
        for (int ph = 0; ph < 4; ph++)
        begin
            set_axes(rand_params(), rand_params(), rand_params());
            queue_random(200);
            drain_all();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_states.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
